>>> rtl/rotary_position_rotate_macros.svh
// Assertion macros shared by the checker.
`ifndef ROTARY_POSITION_ROTATE_MACROS_SVH
`define ROTARY_POSITION_ROTATE_MACROS_SVH
// Implication checked on every rising clock edge outside reset.
`define RPR_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define RPR_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

>>> rtl/rpr_pkg.sv
// ----------------------------------------------------------------------------
// Rotary position rotate package
// Shared constants and the CORDIC arctangent table.
// ----------------------------------------------------------------------------
package rpr_pkg;
  localparam int ATAN_ENTRIES = 24;
  localparam logic [31:0] TURN_SCALE = 32'd683565276;
  localparam logic signed [33:0] CORDIC_X0 = 34'sd652032874;

  // Arctangent of 2^-i in Q0.32 turns.
  function automatic logic [31:0] atan_turns(input logic [4:0] i);
    logic [31:0] v;
    case (i)
      5'd0: v = 32'd536870912;  5'd1: v = 32'd316933406;
      5'd2: v = 32'd167458907;  5'd3: v = 32'd85004756;
      5'd4: v = 32'd42667331;   5'd5: v = 32'd21354465;
      5'd6: v = 32'd10679838;   5'd7: v = 32'd5340245;
      5'd8: v = 32'd2670163;    5'd9: v = 32'd1335087;
      5'd10: v = 32'd667544;    5'd11: v = 32'd333772;
      5'd12: v = 32'd166886;    5'd13: v = 32'd83443;
      5'd14: v = 32'd41722;     5'd15: v = 32'd20861;
      5'd16: v = 32'd10430;     5'd17: v = 32'd5215;
      5'd18: v = 32'd2608;      5'd19: v = 32'd1304;
      5'd20: v = 32'd652;       5'd21: v = 32'd326;
      5'd22: v = 32'd163;       5'd23: v = 32'd81;
      default: v = 32'd0;
    endcase
    return v;
  endfunction
endpackage

>>> rtl/rpr_cordic.sv
// ----------------------------------------------------------------------------
// Rotary position CORDIC
// Reduces the angle to turns and produces cosine and sine in Q2.30 through
// a pipeline of one CORDIC stage per cycle.
// ----------------------------------------------------------------------------
module rpr_cordic #(
  parameter int STAGES = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic [31:0]        in_angle,
  output logic               out_valid,
  output logic signed [33:0] out_cos,
  output logic signed [33:0] out_sin
);
  import rpr_pkg::*;

  localparam int NS = (STAGES > ATAN_ENTRIES) ? ATAN_ENTRIES : STAGES;

  // Stage 0: the 32x32 product for angle reduction.
  logic        v0_r;
  logic [63:0] prod_r;
  always_ff @(posedge clk) begin
    if (!rst_n) v0_r <= 1'b0;
    else v0_r <= in_valid;
    prod_r <= 64'(in_angle) * 64'(TURN_SCALE);
  end

  // Quadrant split and residual.
  logic [31:0] phase;
  logic [1:0]  quad;
  logic [31:0] res;
  assign phase = prod_r[47:16];
  assign quad  = 2'((phase + 32'h2000_0000) >> 30);
  assign res   = phase - {quad, 30'd0};

  logic               v_r [NS+1];
  logic signed [33:0] x_r [NS+1];
  logic signed [33:0] y_r [NS+1];
  logic signed [33:0] z_r [NS+1];
  logic [1:0]         q_r [NS+1];

  always_ff @(posedge clk) begin
    if (!rst_n) v_r[0] <= 1'b0;
    else v_r[0] <= v0_r;
    x_r[0] <= CORDIC_X0;
    y_r[0] <= '0;
    z_r[0] <= 34'(signed'(res));
    q_r[0] <= quad;
  end

  // Rotation stages.
  for (genvar i = 0; i < NS; i++) begin : g_stage
    localparam logic [4:0] IDX = 5'(i);
    logic signed [33:0] a_turn;
    assign a_turn = 34'(atan_turns(IDX));
    always_ff @(posedge clk) begin
      if (!rst_n) v_r[i+1] <= 1'b0;
      else v_r[i+1] <= v_r[i];
      q_r[i+1] <= q_r[i];
      if (!z_r[i][33]) begin
        x_r[i+1] <= x_r[i] - (y_r[i] >>> i);
        y_r[i+1] <= y_r[i] + (x_r[i] >>> i);
        z_r[i+1] <= z_r[i] - a_turn;
      end else begin
        x_r[i+1] <= x_r[i] + (y_r[i] >>> i);
        y_r[i+1] <= y_r[i] - (x_r[i] >>> i);
        z_r[i+1] <= z_r[i] + a_turn;
      end
    end
  end

  // Quadrant mapping.
  logic signed [33:0] xf, yf;
  assign xf = x_r[NS];
  assign yf = y_r[NS];
  always_ff @(posedge clk) begin
    if (!rst_n) out_valid <= 1'b0;
    else out_valid <= v_r[NS];
    case (q_r[NS])
      2'd0: begin out_cos <= xf;  out_sin <= yf;  end
      2'd1: begin out_cos <= -yf; out_sin <= xf;  end
      2'd2: begin out_cos <= -xf; out_sin <= -yf; end
      default: begin out_cos <= yf; out_sin <= -xf; end
    endcase
  end
endmodule

>>> rtl/rpr_lane.sv
// ----------------------------------------------------------------------------
// Rotary position rotation lane
// Rotates one pair by cosine and sine, rounds and saturates.
// ----------------------------------------------------------------------------
module rpr_lane #(
  parameter int DATA_BITS = 16
) (
  input  logic                        clk,
  input  logic signed [DATA_BITS-1:0] in_a,
  input  logic signed [DATA_BITS-1:0] in_b,
  input  logic signed [33:0]          in_cos,
  input  logic signed [33:0]          in_sin,
  output logic signed [DATA_BITS-1:0] out_first,
  output logic signed [DATA_BITS-1:0] out_second
);
  localparam int PW = DATA_BITS + 34;
  localparam int SW = PW + 1;

  // Four products, registered.
  logic signed [PW-1:0] ac_r, bs_r, as_r, bc_r;
  always_ff @(posedge clk) begin
    ac_r <= PW'(in_a) * PW'(in_cos);
    bs_r <= PW'(in_b) * PW'(in_sin);
    as_r <= PW'(in_a) * PW'(in_sin);
    bc_r <= PW'(in_b) * PW'(in_cos);
  end

  function automatic logic signed [DATA_BITS-1:0] rsat(input logic signed [SW-1:0] acc);
    logic signed [SW-1:0] v;
    logic signed [SW-1:0] hi;
    logic signed [SW-1:0] lo;
    hi = SW'((64'sd1 <<< (DATA_BITS - 1)) - 64'sd1);
    lo = -hi - SW'(1);
    v  = (acc + (SW'(1) <<< 29)) >>> 30;
    if (v > hi) v = hi;
    if (v < lo) v = lo;
    return v[DATA_BITS-1:0];
  endfunction

  // Sum, round and saturate.
  always_ff @(posedge clk) begin
    out_first  <= rsat(SW'(ac_r) - SW'(bs_r));
    out_second <= rsat(SW'(as_r) + SW'(bc_r));
  end
endmodule

>>> rtl/rotary_position_rotate.sv
// ----------------------------------------------------------------------------
// Rotary position rotate
// Rotates one query pair and one key pair by a position angle.
// ----------------------------------------------------------------------------
// One transaction is accepted every cycle (busy stays low). Its result
// appears on the out_ ports with out_valid high for one cycle, after the
// angle-reduction multiplier, one CORDIC stage per cycle (CORDIC_STAGES,
// capped at ATAN_ENTRIES) and the registered products and sums of the
// rotation lanes. The receiver cannot stall; results must be taken.
module rotary_position_rotate #(
  parameter int DATA_BITS     = 16,
  parameter int CORDIC_STAGES = 16
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  logic signed [DATA_BITS-1:0] in_q_first,
  input  logic signed [DATA_BITS-1:0] in_q_second,
  input  logic signed [DATA_BITS-1:0] in_k_first,
  input  logic signed [DATA_BITS-1:0] in_k_second,
  input  logic [31:0]                 in_angle,
  output logic                        out_valid,
  output logic signed [DATA_BITS-1:0] out_q_first_rot,
  output logic signed [DATA_BITS-1:0] out_q_second_rot,
  output logic signed [DATA_BITS-1:0] out_k_first_rot,
  output logic signed [DATA_BITS-1:0] out_k_second_rot
);
  import rpr_pkg::*;

  localparam int NS  = (CORDIC_STAGES > ATAN_ENTRIES) ? ATAN_ENTRIES : CORDIC_STAGES;
  localparam int DLY = NS + 3;

  assign busy = 1'b0;

  logic               cs_valid;
  logic signed [33:0] cs_cos, cs_sin;

  rpr_cordic #(.STAGES(CORDIC_STAGES)) u_cordic (
    .clk(clk), .rst_n(rst_n), .in_valid(start), .in_angle(in_angle),
    .out_valid(cs_valid), .out_cos(cs_cos), .out_sin(cs_sin)
  );

  // Data delay line matching the CORDIC latency.
  logic [4*DATA_BITS-1:0] dl_r [DLY];
  always_ff @(posedge clk) begin
    dl_r[0] <= {in_q_first, in_q_second, in_k_first, in_k_second};
    for (int i = 1; i < DLY; i++) dl_r[i] <= dl_r[i-1];
  end

  logic signed [DATA_BITS-1:0] qa, qb, ka, kb;
  assign {qa, qb, ka, kb} = dl_r[DLY-1];

  // Query and key lanes.
  rpr_lane #(.DATA_BITS(DATA_BITS)) u_lane_q (
    .clk(clk), .in_a(qa), .in_b(qb), .in_cos(cs_cos), .in_sin(cs_sin),
    .out_first(out_q_first_rot), .out_second(out_q_second_rot)
  );
  rpr_lane #(.DATA_BITS(DATA_BITS)) u_lane_k (
    .clk(clk), .in_a(ka), .in_b(kb), .in_cos(cs_cos), .in_sin(cs_sin),
    .out_first(out_k_first_rot), .out_second(out_k_second_rot)
  );

  // Valid strobe is delayed to match the lanes' product and output registers.
  logic [1:0] ov_r;
  always_ff @(posedge clk) begin
    if (!rst_n) ov_r <= '0;
    else ov_r <= {ov_r[0], cs_valid};
  end
  assign out_valid = ov_r[1];
endmodule

>>> rtl/rpr_checker.sv
// ----------------------------------------------------------------------------
// Rotary position rotate checker
// Port-level assertions, bound to the top level.
// ----------------------------------------------------------------------------
`include "rotary_position_rotate_macros.svh"
module rpr_checker #(
  parameter int DATA_BITS     = 16,
  parameter int CORDIC_STAGES = 16
) (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 start,
  input logic                 busy,
  input logic                 out_valid,
  input logic [DATA_BITS-1:0] out_q_first_rot,
  input logic [DATA_BITS-1:0] out_q_second_rot
);
  localparam int LAT = ((CORDIC_STAGES > 24) ? 24 : CORDIC_STAGES) + 5;

  logic [LAT-1:0] sh_r;
  always_ff @(posedge clk) begin
    if (!rst_n) sh_r <= '0;
    else sh_r <= {sh_r[LAT-2:0], start && !busy};
  end

  // A result appears exactly when the oldest bit of the start history shows an accepted transaction.
  `RPR_ASSERT_IMP(a_out_matches, clk, rst_n, 1'b1, out_valid == sh_r[LAT-1])
  // The block never refuses a transaction.
  `RPR_ASSERT_IMP(a_never_busy, clk, rst_n, 1'b1, !busy)
  // No result without an earlier transaction in flight.
  `RPR_ASSERT_NXT(a_idle_quiet, clk, rst_n, sh_r == '0, !out_valid || sh_r[LAT-1])
  // A strobed query result carries no unknown bits.
  `RPR_ASSERT_IMP(a_out_known, clk, rst_n, out_valid, !$isunknown({out_q_first_rot, out_q_second_rot}))
endmodule

bind rotary_position_rotate rpr_checker #(
  .DATA_BITS(DATA_BITS), .CORDIC_STAGES(CORDIC_STAGES)
) u_rpr_checker (
  .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .out_valid(out_valid),
  .out_q_first_rot(out_q_first_rot), .out_q_second_rot(out_q_second_rot)
);

>>> dv/tb_rotary_position_rotate.sv
// ----------------------------------------------------------------------------
// Rotary position rotate testbench
// Drives query/key pairs with angles through the rotator and checks each
// rotated result against a bit-accurate CORDIC predictor, first from a
// directed table, then with random transactions under varying sender idling.
// ----------------------------------------------------------------------------
module tb_rotary_position_rotate;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DATA_BITS     = 16;
  localparam int CORDIC_STAGES = 16;
  localparam int LATENCY       = CORDIC_STAGES + 5;
  localparam int WATCHDOG_MAX  = 2000;
  localparam int RANDOM_ITEMS  = 1300;
  localparam logic [31:0] HALF_PI = 32'd102944;

  typedef logic signed [DATA_BITS-1:0] sample_t;

  typedef struct packed {
    sample_t q_first;
    sample_t q_second;
    sample_t k_first;
    sample_t k_second;
  } rotated_t;

  typedef struct {
    sample_t     q_first;
    sample_t     q_second;
    sample_t     k_first;
    sample_t     k_second;
    logic [31:0] angle;
    bit          known;
    rotated_t    rotated;
  } stim_row_t;

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  sample_t     in_q_first, in_q_second, in_k_first, in_k_second;
  logic [31:0] in_angle;
  logic        out_valid;
  sample_t     out_q_first_rot, out_q_second_rot, out_k_first_rot, out_k_second_rot;

  // Typed expectation that travels with the current transaction, if any.
  bit          row_known;
  rotated_t    row_rotated;

  rotated_t    pending_rotations[$];
  int          mismatches;
  int          accepted_items;
  int          checked_results;
  int          idle_count;
  int          sender_idle_pct;

  rotary_position_rotate #(
    .DATA_BITS    (DATA_BITS),
    .CORDIC_STAGES(CORDIC_STAGES)
  ) DUT (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_q_first      (in_q_first),
    .in_q_second     (in_q_second),
    .in_k_first      (in_k_first),
    .in_k_second     (in_k_second),
    .in_angle        (in_angle),
    .out_valid       (out_valid),
    .out_q_first_rot (out_q_first_rot),
    .out_q_second_rot(out_q_second_rot),
    .out_k_first_rot (out_k_first_rot),
    .out_k_second_rot(out_k_second_rot)
  );

  // Arctangent of 2^-i in Q0.32 turns.
  longint arctan_turns[24] = '{
    536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
    10679838, 5340245, 2670163, 1335087, 667544, 333772,
    166886, 83443, 41722, 20861, 10430, 5215, 2608, 1304,
    652, 326, 163, 81
  };

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Round a Q2.30-scaled product to Q4.12 and clamp to the sample range.
  function automatic sample_t round_clamp(input longint acc);
    longint v;
    longint hi;
    hi = (longint'(1) <<< (DATA_BITS - 1)) - 1;
    v  = (acc + (longint'(1) <<< 29)) >>> 30;
    if (v > hi) v = hi;
    if (v < -hi - 1) v = -hi - 1;
    return sample_t'(v);
  endfunction

  // Reduce the angle to turns, run the CORDIC and rotate both pairs.
  function automatic rotated_t rotate_pairs(input sample_t qa, input sample_t qb,
                                            input sample_t ka, input sample_t kb,
                                            input logic [31:0] angle);
    logic [63:0] prod;
    logic [31:0] phase, quad, residual;
    longint      x, y, z, xs, ys, c, s;
    rotated_t    r;
    prod     = {32'd0, angle} * 64'd683565276;
    phase    = prod[47:16];
    quad     = ((phase + 32'h2000_0000) >> 30) & 32'd3;
    residual = phase - (quad << 30);
    z = longint'(signed'(residual));
    x = 652032874;
    y = 0;
    for (int i = 0; i < CORDIC_STAGES && i < 24; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (z >= 0) begin
        x = x - ys; y = y + xs; z = z - arctan_turns[i];
      end else begin
        x = x + ys; y = y - xs; z = z + arctan_turns[i];
      end
    end
    case (quad)
      32'd0:   begin c = x;  s = y;  end
      32'd1:   begin c = -y; s = x;  end
      32'd2:   begin c = -x; s = -y; end
      default: begin c = y;  s = -x; end
    endcase
    r.q_first  = round_clamp(longint'(qa) * c - longint'(qb) * s);
    r.q_second = round_clamp(longint'(qa) * s + longint'(qb) * c);
    r.k_first  = round_clamp(longint'(ka) * c - longint'(kb) * s);
    r.k_second = round_clamp(longint'(ka) * s + longint'(kb) * c);
    return r;
  endfunction

  // Present one transaction and hold it until the block takes it.
  task automatic send_rotation(input stim_row_t row);
    if ($urandom_range(99) < sender_idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(4, 1)) @(posedge clk);
    end
    start       <= 1'b1;
    in_q_first  <= row.q_first;
    in_q_second <= row.q_second;
    in_k_first  <= row.k_first;
    in_k_second <= row.k_second;
    in_angle    <= row.angle;
    row_known   <= row.known;
    row_rotated <= row.rotated;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  // Random sample, biased toward the range ends or toward zero now and then.
  function automatic sample_t pick_sample();
    case ($urandom_range(7))
      0:       return sample_t'(-32768);
      1:       return sample_t'(32767);
      2:       return sample_t'($urandom_range(8, 0) - 4);
      default: return sample_t'($urandom);
    endcase
  endfunction

  // Random angle, sometimes close to a quadrant boundary.
  function automatic logic [31:0] pick_angle();
    if ($urandom_range(3) == 0)
      return HALF_PI * $urandom_range(40) + $urandom_range(6) - 3;
    return $urandom;
  endfunction

  // Record each accepted transaction and check each result strobe.
  always @(posedge clk) begin
    rotated_t expct;
    if (rst_n && start && !busy) begin
      accepted_items <= accepted_items + 1;
      if (row_known)
        pending_rotations.push_back(row_rotated);
      else
        pending_rotations.push_back(rotate_pairs(in_q_first, in_q_second,
                                                 in_k_first, in_k_second, in_angle));
    end
    if (rst_n && out_valid) begin
      if (pending_rotations.size() == 0) begin
        $error("result strobe with no transaction outstanding");
        mismatches = mismatches + 1;
      end else begin
        expct = pending_rotations.pop_front();
        checked_results <= checked_results + 1;
        if (out_q_first_rot !== expct.q_first) begin
          $error("q_first_rot expected %0d got %0d", expct.q_first, out_q_first_rot);
          mismatches = mismatches + 1;
        end
        if (out_q_second_rot !== expct.q_second) begin
          $error("q_second_rot expected %0d got %0d", expct.q_second, out_q_second_rot);
          mismatches = mismatches + 1;
        end
        if (out_k_first_rot !== expct.k_first) begin
          $error("k_first_rot expected %0d got %0d", expct.k_first, out_k_first_rot);
          mismatches = mismatches + 1;
        end
        if (out_k_second_rot !== expct.k_second) begin
          $error("k_second_rot expected %0d got %0d", expct.k_second, out_k_second_rot);
          mismatches = mismatches + 1;
        end
      end
    end
  end

  // Watchdog on cycles in which no transaction or result moves.
  always @(posedge clk) begin
    if ((start && !busy) || out_valid || !rst_n) begin
      idle_count <= 0;
    end else if (idle_count >= WATCHDOG_MAX) begin
      $display("FAILED: results differ");
      $finish;
    end else begin
      idle_count <= idle_count + 1;
    end
  end

  // Directed table, then random phases with different idling.
  initial begin
    stim_row_t table_rows[$];
    stim_row_t row;
    rotated_t  zero_rot;
    zero_rot = '0;
    rst_n = 1'b0; start = 1'b0;
    in_q_first = '0; in_q_second = '0; in_k_first = '0; in_k_second = '0;
    in_angle = '0; row_known = 1'b0; row_rotated = '0;
    mismatches = 0; accepted_items = 0; checked_results = 0; idle_count = 0;
    sender_idle_pct = 0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Zero data rotates to zero at any angle, including the largest.
    table_rows.push_back('{0, 0, 0, 0, 32'd0, 1, zero_rot});
    table_rows.push_back('{0, 0, 0, 0, 32'hFFFF_FFFF, 1, zero_rot});
    table_rows.push_back('{0, 0, 0, 0, HALF_PI * 3, 1, zero_rot});
    // Range ends at the quadrant angles, wraps and saturating diagonals.
    table_rows.push_back('{32767, 32767, -32768, -32768, 32'd0, 0, zero_rot});
    table_rows.push_back('{32767, -32768, -32768, 32767, HALF_PI, 0, zero_rot});
    table_rows.push_back('{-32768, 32767, 32767, -32768, HALF_PI * 2, 0, zero_rot});
    table_rows.push_back('{-32768, -32768, 32767, 32767, HALF_PI * 3, 0, zero_rot});
    table_rows.push_back('{32767, 32767, -32768, -32768, 32'd51472, 0, zero_rot});
    table_rows.push_back('{-32768, 32767, 32767, -32768, 32'd154416, 0, zero_rot});
    table_rows.push_back('{4096, 0, 0, 4096, 32'd411775, 0, zero_rot});
    table_rows.push_back('{4096, 0, 0, 4096, 32'hFFFF_FFFF, 0, zero_rot});
    table_rows.push_back('{4096, -4096, 1, -1, 32'h8000_0000, 0, zero_rot});
    table_rows.push_back('{-1, 1, 32767, 0, 32'd1, 0, zero_rot});
    table_rows.push_back('{12345, -23456, -3, 7, HALF_PI - 1, 0, zero_rot});
    table_rows.push_back('{-32768, 0, 0, -32768, HALF_PI * 2 + 1, 0, zero_rot});
    table_rows.push_back('{32767, 32767, 32767, 32767, 32'h7FFF_FFFF, 0, zero_rot});
    foreach (table_rows[i]) send_rotation(table_rows[i]);

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      sender_idle_pct = (n < RANDOM_ITEMS / 3) ? 6 : (n < 2 * RANDOM_ITEMS / 3) ? 87 : 0;
      row.q_first  = pick_sample();
      row.q_second = pick_sample();
      row.k_first  = pick_sample();
      row.k_second = pick_sample();
      row.angle    = pick_angle();
      row.known    = 1'b0;
      row.rotated  = zero_rot;
      send_rotation(row);
    end
    start <= 1'b0;

    // Drain outstanding results, then watch for stray strobes.
    while (pending_rotations.size() != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
    $display("Covered %0d transactions (directed table plus random) and checked %0d results.",
             accepted_items, checked_results);
    $display("Sender idling ran at 6%%, 87%% and 0%% across the random phases.");
    if (mismatches == 0)
      $display("PASSED: all results match");
    else
      $display("FAILED: results differ");
    $finish;
  end
endmodule
